FILE: sv/assert_macros.svh
// Assertion macros for the RTL files of the edge set table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: sv/uest_pkg.sv
// Shared constants, types and helper functions of the edge set table
`timescale 1ns / 1ps

package uest_pkg;

    localparam int MAX_EDGES    = 32;
    localparam int MAX_VERTICES = 32;

    localparam int OP_W     = 2;
    localparam int ID_W     = 6;
    localparam int WEIGHT_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam int IDX_W   = $clog2(MAX_EDGES);
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    localparam int VID_W   = $clog2(MAX_VERTICES);
    localparam int VC_W    = $clog2(MAX_VERTICES + 1);
    localparam int VU_W    = $clog2(2 * MAX_EDGES + 1);
    localparam int VNUM_W  = ($clog2(MAX_VERTICES + 1) > ID_W) ?
                             $clog2(MAX_VERTICES + 1) : ID_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]     a;
        logic [ID_W-1:0]     b;
        logic [WEIGHT_W-1:0] w;
    } edge_t;

    typedef struct packed {
        logic load;
        logic shift;
    } edge_ctl_t;

    typedef struct packed {
        logic            clr;
        logic            add;
        logic            del;
        logic [ID_W-1:0] va;
        logic [ID_W-1:0] vb;
    } vtx_ctl_t;

    function automatic logic [IDX_W-1:0] last_set(input logic [MAX_EDGES-1:0] m);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_EDGES; i++)
        begin
            if (m[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic id_in_range(input logic [ID_W-1:0] v);
        return (v != '0) && (VNUM_W'(v) <= VNUM_W'(MAX_VERTICES));
    endfunction

    function automatic logic [VID_W-1:0] id_index(input logic [ID_W-1:0] v);
        return VID_W'(VNUM_W'(v) - VNUM_W'(1));
    endfunction

endpackage

FILE: sv/uest_edge_cell.sv
// One slot of the edge chain: holds an edge, matches it and shifts it down
`timescale 1ns / 1ps

module uest_edge_cell (
    input  logic                      clk,
    input  uest_pkg::edge_ctl_t       ctl,
    input  logic                      valid,
    input  logic [uest_pkg::ID_W-1:0] qa,
    input  logic [uest_pkg::ID_W-1:0] qb,
    input  uest_pkg::edge_t           din,
    input  uest_pkg::edge_t           up,
    output uest_pkg::edge_t           q,
    output logic                      match
);
    import uest_pkg::*;

    edge_t edge_reg;
    edge_t edge_next;

    always_comb
    begin
        priority if (ctl.load)
        begin
            edge_next = din;
        end
        else if (ctl.shift)
        begin
            edge_next = up;
        end
        else
        begin
            edge_next = edge_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
    end

    assign q     = edge_reg;
    assign match = valid && (((edge_reg.a == qa) && (edge_reg.b == qb)) ||
                             ((edge_reg.a == qb) && (edge_reg.b == qa)));

endmodule

FILE: sv/uest_vertex_cell.sv
// One vertex id: counts the endpoints of stored edges that carry it
`timescale 1ns / 1ps

module uest_vertex_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  uest_pkg::vtx_ctl_t            ctl,
    input  logic [uest_pkg::VNUM_W-1:0]   my_id,
    output logic                          used,
    output logic                          single
);
    import uest_pkg::*;

    logic [VU_W-1:0] uses_reg;
    logic [VU_W-1:0] uses_next;
    logic            hit;

    assign hit = (VNUM_W'(ctl.va) == my_id) || (VNUM_W'(ctl.vb) == my_id);

    always_comb
    begin
        priority if (ctl.clr)
        begin
            uses_next = '0;
        end
        else if (ctl.add && hit)
        begin
            uses_next = uses_reg + VU_W'(1);
        end
        else if (ctl.del && hit && (uses_reg != '0))
        begin
            uses_next = uses_reg - VU_W'(1);
        end
        else
        begin
            uses_next = uses_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uses_reg <= '0;
        end
        else
        begin
            uses_reg <= uses_next;
        end
    end

    assign used   = (uses_reg != '0);
    assign single = (uses_reg == VU_W'(1));

endmodule

FILE: sv/undirected_edge_set_table.sv
// Top level of the undirected edge set table: control, edge chain and vertex cells
//
//  channel   handshake         payload
//  request   start / busy      op, vertex_a, vertex_b, weight_bits
//  result    done (1 cycle)    status, edge_count, vertex_count
//
//  Each request passes S_MATCH, which matches all edge cells at once and finds
//  the last hit, then S_APPLY, which inserts, clears or shifts the chain down
//  a slot to delete, and updates counts. busy is high only in S_MATCH. A new
//  request may start during S_APPLY; its result is registered after S_APPLY.
//  Reset empties the table and clears every vertex use count at once.
//  The receiver cannot stall: done holds for one cycle only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module undirected_edge_set_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [uest_pkg::OP_W-1:0]      op,
    input  logic [uest_pkg::ID_W-1:0]      vertex_a,
    input  logic [uest_pkg::ID_W-1:0]      vertex_b,
    input  logic [uest_pkg::WEIGHT_W-1:0]  weight_bits,
    output logic                           done,
    output logic [uest_pkg::STATUS_W-1:0]  status,
    output logic [uest_pkg::COUNT_W-1:0]   edge_count,
    output logic [uest_pkg::COUNT_W-1:0]   vertex_count
);
    import uest_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [VC_W-1:0]       vc_reg;
    logic [VC_W-1:0]       vc_next;
    logic                  found_reg;
    logic [IDX_W-1:0]      hit_reg;

    logic [OP_W-1:0]       op_reg;
    logic [ID_W-1:0]       va_reg;
    logic [ID_W-1:0]       vb_reg;
    logic [WEIGHT_W-1:0]   wt_reg;

    logic                  accept;
    logic                  apply;
    logic                  full;
    logic                  do_ins;
    logic                  do_del;
    logic                  do_clr;
    logic                  ina;
    logic                  inb;
    logic [VID_W-1:0]      ia;
    logic [VID_W-1:0]      ib;
    logic [1:0]            rise;
    logic [1:0]            fall;

    logic [MAX_EDGES-1:0]    match_vec;
    edge_t                   cell_q [MAX_EDGES];
    edge_t                   cell_up [MAX_EDGES];
    edge_t                   new_edge;
    logic [MAX_VERTICES-1:0] used_vec;
    logic [MAX_VERTICES-1:0] single_vec;
    vtx_ctl_t                vctl;

    assign busy   = (state_reg == S_MATCH);
    assign accept = start && !busy;
    assign apply  = (state_reg == S_APPLY);

    assign full   = (count_reg == CNT_W'(MAX_EDGES));
    assign do_ins = apply && (op_reg == OP_INSERT) && !full;
    assign do_del = apply && (op_reg == OP_DELETE) && found_reg;
    assign do_clr = apply && (op_reg == OP_CLEAR);

    assign new_edge = '{a: va_reg, b: vb_reg, w: wt_reg};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EDGES; gi++)
        begin : g_edge
            edge_ctl_t ectl;

            if (gi == MAX_EDGES - 1)
            begin : g_top
                assign cell_up[gi] = '0;
            end
            else
            begin : g_mid
                assign cell_up[gi] = cell_q[gi + 1];
            end

            assign ectl.load  = do_ins && (count_reg == CNT_W'(gi));
            assign ectl.shift = do_del && (IDX_W'(gi) >= hit_reg);

            uest_edge_cell u_cell (
                .clk   (clk),
                .ctl   (ectl),
                .valid (CNT_W'(gi) < count_reg),
                .qa    (va_reg),
                .qb    (vb_reg),
                .din   (new_edge),
                .up    (cell_up[gi]),
                .q     (cell_q[gi]),
                .match (match_vec[gi])
            );
        end

        for (gi = 0; gi < MAX_VERTICES; gi++)
        begin : g_vtx
            uest_vertex_cell u_vcell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (vctl),
                .my_id  (VNUM_W'(gi + 1)),
                .used   (used_vec[gi]),
                .single (single_vec[gi])
            );
        end
    endgenerate

    assign vctl.clr = do_clr;
    assign vctl.add = do_ins;
    assign vctl.del = do_del;
    assign vctl.va  = va_reg;
    assign vctl.vb  = vb_reg;

    assign ina = id_in_range(va_reg);
    assign inb = id_in_range(vb_reg) && (vb_reg != va_reg);
    assign ia  = id_index(va_reg);
    assign ib  = id_index(vb_reg);

    assign rise = {1'b0, ina && !used_vec[ia]} + {1'b0, inb && !used_vec[ib]};
    assign fall = {1'b0, ina && single_vec[ia]} + {1'b0, inb && single_vec[ib]};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        vc_next     = vc_reg;
        status_next = ST_OK;

        if (apply)
        begin
            priority if (do_clr)
            begin
                count_next = '0;
                vc_next    = '0;
            end
            else if (do_ins)
            begin
                count_next = count_reg + CNT_W'(1);
                vc_next    = vc_reg + VC_W'(rise);
            end
            else if (do_del)
            begin
                count_next = count_reg - CNT_W'(1);
                vc_next    = vc_reg - VC_W'(fall);
            end
            else if (op_reg == OP_INSERT)
            begin
                status_next = ST_FULL;
            end
            else if (op_reg == OP_DELETE)
            begin
                status_next = ST_NOT_FOUND;
            end
            else
            begin
                status_next = ST_OK;
            end
        end

        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_MATCH : S_IDLE;
            S_MATCH: state_next = S_APPLY;
            S_APPLY: state_next = accept ? S_MATCH : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            count_reg  <= '0;
            vc_reg     <= '0;
            found_reg  <= 1'b0;
            hit_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= apply;
            if (apply)
            begin
                status_reg <= status_next;
            end
            count_reg <= count_next;
            vc_reg    <= vc_next;
            if (state_reg == S_MATCH)
            begin
                found_reg <= |match_vec;
                hit_reg   <= last_set(match_vec);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
            va_reg <= vertex_a;
            vb_reg <= vertex_b;
            wt_reg <= weight_bits;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign edge_count   = COUNT_W'(count_reg);
    assign vertex_count = COUNT_W'(vc_reg);

    `ASSERT_CLK(a_done_after_apply, done_reg |-> $past(state_reg == S_APPLY))
    `ASSERT_CLK(a_accept_busy, accept |=> busy)
    `ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(MAX_EDGES))
    `ASSERT_CLK(a_full_count, (done_reg && (status_reg == ST_FULL)) |-> full)

endmodule
